FILE: rtl/core/zma_pkg.sv
// Package for the zone motion accumulator.
// Holds frame and field sizes, register reset values, codes and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package zma_pkg;

    // Frame geometry and zone count.
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int ZONE_COUNT   = 3;
    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

    // Counter and address widths derived from the geometry.
    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
    localparam int ADDR_W = $clog2(FRAME_PIXELS);
    localparam int ZONE_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

    // Field and register widths.
    localparam int GRAY_W     = 8;
    localparam int LEFT_W     = 10;
    localparam int TOP_W      = 9;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;
    localparam int THRESH_W   = 16;
    localparam int GOAL_W     = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int ZONE_IDX_W = 2;

    // Arithmetic widths.
    localparam int SUM_W  = 27;
    localparam int AREA_W = WIDTH_W + HEIGHT_W;
    localparam int FRAC_W = 8;
    localparam int AVG_W  = 16;
    localparam int POS_W  = 17;
    localparam int DIVD_W = SUM_W + FRAC_W;
    localparam int PROD_W = 2 * AVG_W;

    // Division by ten as a multiplication by a reciprocal, exact for 16-bit values.
    localparam logic [AVG_W-1:0] RECIP_TEN   = 16'hCCCD;
    localparam int               RECIP_SHIFT = 19;
    localparam int               DEC_W       = PROD_W - RECIP_SHIFT;

    // Comparison widths for zone membership, one bit of headroom for the right edge.
    localparam int COL_CMP_W = ((COL_W > LEFT_W) ? COL_W : LEFT_W) + 1;
    localparam int ROW_CMP_W = ((ROW_W > TOP_W) ? ROW_W : TOP_W) + 1;

    // Register reset values.
    localparam logic [LEFT_W-1:0]   LEFT_A_RESET    = 10'd50;
    localparam logic [LEFT_W-1:0]   LEFT_B_RESET    = 10'd250;
    localparam logic [LEFT_W-1:0]   LEFT_C_RESET    = 10'd450;
    localparam logic [TOP_W-1:0]    TOP_RESET       = 9'd320;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 10'd150;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 9'd150;
    localparam logic [THRESH_W-1:0] THRESH_RESET    = 16'd1280;
    localparam logic [GOAL_W-1:0]   GOAL_RESET      = 9'd10;
    localparam logic [POS_W-1:0]    POS_RESET       = {TOP_RESET, 8'd0};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_A    = 3'd0,
        CFG_LEFT_B    = 3'd1,
        CFG_LEFT_C    = 3'd2,
        CFG_TOP       = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5,
        CFG_THRESHOLD = 3'd6,
        CFG_GOAL      = 3'd7
    } t_cfg_idx;

    // Zone geometry handed to the pixel path.
    typedef struct packed {
        logic [ZONE_COUNT-1:0][LEFT_W-1:0] left;
        logic [TOP_W-1:0]                  top;
        logic [WIDTH_W-1:0]                width;
        logic [HEIGHT_W-1:0]               height;
    } t_zone_cfg;

    // Sequencer commands to the pixel path.
    typedef struct packed {
        logic              process;
        logic [GRAY_W-1:0] gray;
        logic              frame_end;
        logic              sum_clr;
    } t_pix_ctrl;

    // Pixel path status back to the sequencer.
    typedef struct packed {
        logic                             clear_busy;
        logic [ZONE_COUNT-1:0][SUM_W-1:0] sums;
    } t_pix_stat;

    // Zone counter to the two-bit result field.
    function automatic logic [ZONE_IDX_W-1:0] zone_idx_field(input logic [ZONE_W-1:0] zone);
        logic [31:0] wide;
        wide = 32'(zone);
        return wide[ZONE_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/zma_pixel_if.sv
// Pixel stream channel: valid/ready handshake with grey level and frame-end mark.
// Depends on zma_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface zma_pixel_if import zma_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] pixel_gray;
    logic              frame_end;

    modport source (output valid, output pixel_gray, output frame_end, input ready);
    modport sink   (input valid, input pixel_gray, input frame_end, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/zma_result_if.sv
// Zone result channel: valid/ready handshake with one zone report per transfer.
// Depends on zma_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface zma_result_if import zma_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [ZONE_IDX_W-1:0] zone_index;
    logic [AVG_W-1:0]      motion_average;
    logic [POS_W-1:0]      zone_position;
    logic                  goal_reached;
    logic                  last_zone;

    modport source (
        output valid, output zone_index, output motion_average,
        output zone_position, output goal_reached, output last_zone,
        input  ready
    );
    modport sink (
        input  valid, input zone_index, input motion_average,
        input  zone_position, input goal_reached, input last_zone,
        output ready
    );

endinterface

`default_nettype wire

FILE: rtl/core/zma_pixel_path.sv
// Pixel path: previous-frame store with its clearing sweep, raster counters
// and per-zone difference sums. Depends on zma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zma_pixel_path import zma_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_pix_ctrl i_ctrl,
    input  wire t_zone_cfg i_zone,
    output t_pix_stat      o_stat
);

    logic [GRAY_W-1:0] r_frame_mem [FRAME_PIXELS];
    logic [GRAY_W-1:0] r_rd_data;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_addr;
    logic [ZONE_COUNT-1:0][SUM_W-1:0] r_sums;

    logic                  in_frame;
    logic [GRAY_W-1:0]     diff;
    logic [ZONE_COUNT-1:0] in_zone;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [GRAY_W-1:0]     wr_data;
    logic                  store_pixel;

    // Pixels past the last row are neither stored nor summed.
    assign in_frame    = (r_row < ROW_W'(FRAME_HEIGHT));
    assign store_pixel = i_ctrl.process && in_frame;

    // Absolute difference against the stored pixel read in the transfer cycle.
    assign diff = (i_ctrl.gray > r_rd_data) ? (i_ctrl.gray - r_rd_data)
                                            : (r_rd_data - i_ctrl.gray);

    // Zone membership of the current raster position.
    always_comb begin
        logic [COL_CMP_W-1:0] col_x;
        logic [ROW_CMP_W-1:0] row_x;
        logic [COL_CMP_W-1:0] left_x;
        logic [COL_CMP_W-1:0] right_x;
        logic [ROW_CMP_W-1:0] top_x;
        logic [ROW_CMP_W-1:0] bottom_x;
        logic                 row_ok;
        col_x    = COL_CMP_W'(r_col);
        row_x    = ROW_CMP_W'(r_row);
        top_x    = ROW_CMP_W'(i_zone.top);
        bottom_x = top_x + ROW_CMP_W'(i_zone.height);
        row_ok   = (row_x >= top_x) && (row_x < bottom_x);
        for (int z = 0; z < ZONE_COUNT; z++) begin
            left_x     = COL_CMP_W'(i_zone.left[z]);
            right_x    = left_x + COL_CMP_W'(i_zone.width);
            in_zone[z] = row_ok && (col_x >= left_x) && (col_x < right_x);
        end
    end

    // Single write port shared by the clearing sweep and pixel stores.
    always_comb begin
        wr_en   = r_clr_busy || store_pixel;
        wr_addr = r_clr_busy ? r_clr_addr : r_addr;
        wr_data = r_clr_busy ? '0 : i_ctrl.gray;
    end

    // Frame store, written at one address and read at the raster address.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_frame_mem[r_addr];
    end

    // Clearing sweep after reset, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(FRAME_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Raster counters; the frame-end pixel returns them to the origin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
        end else if (i_ctrl.process) begin
            if (i_ctrl.frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_addr <= '0;
            end else if (in_frame) begin
                r_addr <= r_addr + 1'b1;
                if (r_col == COL_W'(FRAME_WIDTH - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Zone sums wrap at their width and clear once all zones are reported.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_ctrl.sum_clr) begin
            r_sums <= '0;
        end else if (store_pixel) begin
            for (int z = 0; z < ZONE_COUNT; z++) begin
                if (in_zone[z]) begin
                    r_sums[z] <= r_sums[z] + SUM_W'(diff);
                end
            end
        end
    end

    assign o_stat.clear_busy = r_clr_busy;
    assign o_stat.sums       = r_sums;

endmodule

`default_nettype wire

FILE: rtl/core/zma_divider.sv
// Shared restoring divider: Q8.8 mean of a zone sum over the zone area,
// one quotient bit per cycle, saturating at the top of the range. Depends on zma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zma_divider import zma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_sum,
    input  wire logic [AREA_W-1:0] i_area,
    output logic                   o_done,
    output logic [AVG_W-1:0]       o_quo
);

    localparam int STEP_W = $clog2(AVG_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_div;
    logic [AVG_W-1:0]  r_quo;

    logic [DIVD_W-1:0] dividend;
    logic [DIVD_W-1:0] sat_limit;
    logic              zero_area;
    logic              saturate;
    logic              ge;

    // The mean saturates when it would not fit the quotient width.
    assign dividend  = {i_sum, FRAC_W'(0)};
    assign sat_limit = DIVD_W'(i_area) << AVG_W;
    assign zero_area = (i_area == '0);
    assign saturate  = (dividend >= sat_limit);
    assign ge        = (r_rem >= r_div);

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (zero_area || saturate) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= STEP_W'(AVG_W - 1);
                end
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Compare, subtract and shift, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dividend;
            r_div <= DIVD_W'(i_area) << (AVG_W - 1);
            if (zero_area) begin
                r_quo <= '0;
            end else if (saturate) begin
                r_quo <= '1;
            end else begin
                r_quo <= '0;
            end
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[AVG_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: rtl/core/zone_motion_accumulator.sv
// Top level of the zone motion accumulator: configuration registers, sequencer,
// zone position update and result register. Depends on zma_pkg, zma_pixel_if,
// zma_result_if, zma_pixel_path and zma_divider.
//
//  Channel    Direction  Handshake       Carries
//  i_pixel    in         valid / ready   pixel_gray, frame_end
//  o_result   out        valid / ready   zone_index, motion_average, zone_position,
//                                        goal_reached, last_zone
//  i_cfg_*    in         write enable    register index, write data
//
// An ordinary pixel passes through the transfer, which also reads the stored pixel, and
// S_PIXEL, which writes the store and updates the zone sums.
// A frame-end pixel then adds, per zone, a start step, the divider steps, the multiply by
// a tenth, the position update and the result load (plus an area step per frame).
// After reset the frame store is cleared one entry per cycle, and no pixel is taken
// meanwhile. A stalled result holds the sequencer before the next zone; the last result
// of a frame may wait while the next pixel is taken.
`timescale 1ns / 1ps
`default_nettype none

module zone_motion_accumulator import zma_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    zma_pixel_if.sink                  i_pixel,
    zma_result_if.source               o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PIXEL  = 9'b000000100,
        S_AREA   = 9'b000001000,
        S_DSTART = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_DEC    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [LEFT_W-1:0]   r_left_a;
    logic [LEFT_W-1:0]   r_left_b;
    logic [LEFT_W-1:0]   r_left_c;
    logic [TOP_W-1:0]    r_top;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [THRESH_W-1:0] r_threshold;
    logic [GOAL_W-1:0]   r_goal;

    // Sequencer and datapath registers.
    logic [GRAY_W-1:0] r_gray;
    logic              r_frame_end;
    logic [ZONE_W-1:0] r_zone;
    logic [AREA_W-1:0] r_area;
    logic [AVG_W-1:0]  r_avg;
    logic [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]  r_pos [ZONE_COUNT];

    // Result register.
    logic                  r_out_valid;
    logic [ZONE_IDX_W-1:0] r_out_zone;
    logic [AVG_W-1:0]      r_out_avg;
    logic [POS_W-1:0]      r_out_pos;
    logic                  r_out_goal;
    logic                  r_out_last;

    t_zone_cfg zone_cfg;
    t_pix_ctrl pix_ctrl;
    t_pix_stat pix_stat;

    logic             pix_xfer;
    logic             out_xfer;
    logic             can_load;
    logic             last_zone;
    logic             div_start;
    logic             div_done;
    logic [AVG_W-1:0] div_quo;
    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] new_pos;
    logic [POS_W-1:0] dec_ext;
    logic [DEC_W-1:0] dec;

    assign pix_xfer  = i_pixel.valid && i_pixel.ready;
    assign out_xfer  = r_out_valid && o_result.ready;
    assign can_load  = !r_out_valid || o_result.ready;
    assign last_zone = (r_zone == ZONE_W'(ZONE_COUNT - 1));
    assign div_start = (r_state == S_DSTART);
    assign cur_pos   = r_pos[r_zone];

    assign i_pixel.ready = (r_state == S_IDLE);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_a    <= LEFT_A_RESET;
            r_left_b    <= LEFT_B_RESET;
            r_left_c    <= LEFT_C_RESET;
            r_top       <= TOP_RESET;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_threshold <= THRESH_RESET;
            r_goal      <= GOAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_A:    r_left_a    <= i_cfg_data[LEFT_W-1:0];
                CFG_LEFT_B:    r_left_b    <= i_cfg_data[LEFT_W-1:0];
                CFG_LEFT_C:    r_left_c    <= i_cfg_data[LEFT_W-1:0];
                CFG_TOP:       r_top       <= i_cfg_data[TOP_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[HEIGHT_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_GOAL:      r_goal      <= i_cfg_data[GOAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Zone geometry; every zone after the second shares the third left column.
    always_comb begin
        for (int z = 0; z < ZONE_COUNT; z++) begin
            if (z == 0) begin
                zone_cfg.left[z] = r_left_a;
            end else if (z == 1) begin
                zone_cfg.left[z] = r_left_b;
            end else begin
                zone_cfg.left[z] = r_left_c;
            end
        end
        zone_cfg.top    = r_top;
        zone_cfg.width  = r_width;
        zone_cfg.height = r_height;
    end

    // Commands to the pixel path.
    always_comb begin
        pix_ctrl.process   = (r_state == S_PIXEL);
        pix_ctrl.gray      = r_gray;
        pix_ctrl.frame_end = r_frame_end;
        pix_ctrl.sum_clr   = (r_state == S_EMIT) && can_load && last_zone;
    end

    zma_pixel_path u_pixel_path (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (pix_ctrl),
        .i_zone  (zone_cfg),
        .o_stat  (pix_stat)
    );

    zma_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (pix_stat.sums[r_zone]),
        .i_area  (r_area),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Position step: a tenth of the mean, taken off only above the threshold.
    assign dec     = r_prod[RECIP_SHIFT +: DEC_W];
    assign dec_ext = POS_W'(dec);
    always_comb begin
        new_pos = cur_pos;
        if (r_avg > r_threshold) begin
            new_pos = (cur_pos > dec_ext) ? (cur_pos - dec_ext) : '0;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (!pix_stat.clear_busy) n_state = S_IDLE;
            S_IDLE:   if (pix_xfer) n_state = S_PIXEL;
            S_PIXEL:  n_state = r_frame_end ? S_AREA : S_IDLE;
            S_AREA:   n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_MUL;
            S_MUL:    n_state = S_DEC;
            S_DEC:    n_state = S_EMIT;
            S_EMIT: begin
                if (can_load) begin
                    n_state = last_zone ? S_IDLE : S_DSTART;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Sequencer state and zone counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_zone  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PIXEL) begin
                r_zone <= '0;
            end else if ((r_state == S_EMIT) && can_load && !last_zone) begin
                r_zone <= r_zone + 1'b1;
            end
        end
    end

    // Pixel capture, area, mean and reciprocal product.
    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_gray      <= i_pixel.pixel_gray;
            r_frame_end <= i_pixel.frame_end;
        end
        if (r_state == S_AREA) begin
            r_area <= AREA_W'(r_width) * AREA_W'(r_height);
        end
        if ((r_state == S_DIV) && div_done) begin
            r_avg <= div_quo;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_avg) * PROD_W'(RECIP_TEN);
        end
    end

    // Zone positions start at the reset top row and persist across frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < ZONE_COUNT; z++) begin
                r_pos[z] <= POS_RESET;
            end
        end else if (r_state == S_DEC) begin
            r_pos[r_zone] <= new_pos;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && can_load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && can_load) begin
            r_out_zone <= zone_idx_field(r_zone);
            r_out_avg  <= r_avg;
            r_out_pos  <= cur_pos;
            r_out_goal <= (cur_pos <= POS_W'({r_goal, FRAC_W'(0)}));
            r_out_last <= last_zone;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.zone_index     = r_out_zone;
    assign o_result.motion_average = r_out_avg;
    assign o_result.zone_position  = r_out_pos;
    assign o_result.goal_reached   = r_out_goal;
    assign o_result.last_zone      = r_out_last;

endmodule

`default_nettype wire

FILE: verif/tb_zone_motion_accumulator.sv
// Self-checking testbench for zone_motion_accumulator: pixel frames in, zone reports out.
// Depends on zma_pkg, zma_pixel_if, zma_result_if and the block's RTL; a scoreboard class
// predicts every zone report and compares it with what the block returns.
`timescale 1ns / 1ps

module tb_zone_motion_accumulator;
    import zma_pkg::*;

    // Run control.
    localparam int unsigned ITEM_TARGET    = 370;
    localparam int unsigned REPORT_TARGET  = 72;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned END_CYCLES     = 100;
    localparam int unsigned WATCHDOG_LIMIT = 3 * FRAME_PIXELS;

    // One zone report as it leaves the block.
    typedef struct packed {
        logic [ZONE_IDX_W-1:0] zone_index;
        logic [AVG_W-1:0]      motion_average;
        logic [POS_W-1:0]      zone_position;
        logic                  goal_reached;
        logic                  last_zone;
    } zone_report_t;

    // Receiver stall patterns.
    typedef enum int unsigned {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PATTERN} rx_mode_t;

    // Keeps its own copy of the frame store, zone sums and positions, and the expected reports.
    class zone_motion_scoreboard;
        int unsigned  zone_left [3];
        int unsigned  zone_top, zone_width, zone_height, threshold, goal_level;
        byte unsigned prev_frame [];
        int unsigned  zone_sum [ZONE_COUNT];
        int unsigned  zone_pos [ZONE_COUNT];
        int unsigned  column, row;
        zone_report_t expected_reports [$];
        int unsigned  mismatches;
        int unsigned  reports_checked;

        function new();
            int z;
            zone_left[0] = LEFT_A_RESET;
            zone_left[1] = LEFT_B_RESET;
            zone_left[2] = LEFT_C_RESET;
            zone_top     = TOP_RESET;
            zone_width   = WIDTH_RESET;
            zone_height  = HEIGHT_RESET;
            threshold    = THRESH_RESET;
            goal_level   = GOAL_RESET;
            prev_frame   = new[FRAME_PIXELS];
            for (z = 0; z < ZONE_COUNT; z++) begin
                zone_sum[z] = 0;
                zone_pos[z] = POS_RESET;
            end
            column          = 0;
            row             = 0;
            mismatches      = 0;
            reports_checked = 0;
        endfunction

        // A register write keeps only the bits the register holds.
        function void apply_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LEFT_A:    zone_left[0] = data[LEFT_W-1:0];
                CFG_LEFT_B:    zone_left[1] = data[LEFT_W-1:0];
                CFG_LEFT_C:    zone_left[2] = data[LEFT_W-1:0];
                CFG_TOP:       zone_top     = data[TOP_W-1:0];
                CFG_WIDTH:     zone_width   = data[WIDTH_W-1:0];
                CFG_HEIGHT:    zone_height  = data[HEIGHT_W-1:0];
                CFG_THRESHOLD: threshold    = data[THRESH_W-1:0];
                CFG_GOAL:      goal_level   = data[GOAL_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulates one accepted pixel; a frame-end pixel yields one report per zone.
        function void take_pixel(input logic [GRAY_W-1:0] gray, input logic last_px);
            int unsigned     addr, old_gray, diff, left, z;
            longint unsigned area, avg, dec;
            zone_report_t    report;
            // Pixels past the last row are neither stored nor summed.
            if (row < FRAME_HEIGHT && column < FRAME_WIDTH) begin
                addr     = row * FRAME_WIDTH + column;
                old_gray = prev_frame[addr];
                diff     = (gray > old_gray) ? gray - old_gray : old_gray - gray;
                prev_frame[addr] = gray;
                for (z = 0; z < ZONE_COUNT; z++) begin
                    left = zone_left[(z < 2) ? z : 2];
                    if (column >= left && column < left + zone_width &&
                        row >= zone_top && row < zone_top + zone_height)
                        zone_sum[z] = (zone_sum[z] + diff) & 32'h07FF_FFFF;
                end
                column++;
                if (column >= FRAME_WIDTH) begin
                    column = 0;
                    row++;
                end
            end
            if (!last_px)
                return;
            area = zone_width;
            area = area * zone_height;
            for (z = 0; z < ZONE_COUNT; z++) begin
                avg = 0;
                if (area != 0) begin
                    avg = zone_sum[z];
                    avg = (avg << 8) / area;
                end
                if (avg > 64'hFFFF)
                    avg = 64'hFFFF;
                // A moving zone steps down by a tenth of its mean and stops at zero.
                if (avg > threshold) begin
                    dec = avg / 10;
                    zone_pos[z] = (zone_pos[z] > dec) ? zone_pos[z] - dec : 0;
                end
                zone_pos[z] = zone_pos[z] & 32'h1FFFF;
                report.zone_index     = ZONE_IDX_W'(z);
                report.motion_average = AVG_W'(avg);
                report.zone_position  = POS_W'(zone_pos[z]);
                report.goal_reached   = (zone_pos[z] <= (goal_level << 8));
                report.last_zone      = (z == ZONE_COUNT - 1);
                expected_reports.insert(expected_reports.size(), report);
                zone_sum[z] = 0;
            end
            column = 0;
            row    = 0;
        endfunction

        function void compare_field(input string field, input logic [31:0] want,
                                    input logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0d, actual %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        // Compares a returned report with the oldest one still expected.
        function void check_report(input zone_report_t got);
            zone_report_t want;
            if (expected_reports.size() == 0) begin
                $error("zone report with none expected: zone_index %0d", got.zone_index);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            compare_field("zone_index", want.zone_index, got.zone_index);
            compare_field("motion_average", want.motion_average, got.motion_average);
            compare_field("zone_position", want.zone_position, got.zone_position);
            compare_field("goal_reached", want.goal_reached, got.goal_reached);
            compare_field("last_zone", want.last_zone, got.last_zone);
        endfunction

        function int unsigned pending_count();
            return expected_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    zma_pixel_if  pix_if ();
    zma_result_if res_if ();

    zone_motion_scoreboard board;
    int                    hold_requests = 0;
    bit                    gaps_on       = 1'b1;
    int unsigned           burst_left    = 0;
    int unsigned           pixels_sent   = 0;

    zone_motion_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (pix_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one pixel and waits for its transfer; a new burst may open with a gap.
    task automatic send_pixel(input logic [GRAY_W-1:0] gray, input logic last_px);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel_gray <= gray;
        pix_if.frame_end  <= last_px;
        @(posedge i_clk);
        while (pix_if.ready !== 1'b1) @(posedge i_clk);
        pixels_sent++;
        if (burst_left != 0)
            burst_left--;
    endtask

    // Stops offering, waits for every expected report, then lets a trailing pixel finish.
    task automatic quiesce();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Grey levels lean towards the extremes so that full-scale differences are common.
    function automatic logic [GRAY_W-1:0] random_gray();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Tracks every transfer and register write on the clock edge at which it happens.
    always @(posedge i_clk) begin : transfer_monitor
        zone_report_t got;
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we)
                board.apply_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (pix_if.valid && pix_if.ready)
                board.take_pixel(pix_if.pixel_gray, pix_if.frame_end);
            if (res_if.valid && res_if.ready) begin
                got.zone_index     = res_if.zone_index;
                got.motion_average = res_if.motion_average;
                got.zone_position  = res_if.zone_position;
                got.goal_reached   = res_if.goal_reached;
                got.last_zone      = res_if.last_zone;
                board.check_report(got);
            end
        end
    end

    // Result receiver: changing stall patterns, plus a long hold-off when one is requested.
    initial begin : result_receiver
        rx_mode_t    mode;
        int unsigned mode_left, hold_left;
        int          holds_taken;
        logic [7:0]  stall_mask;
        res_if.ready = 1'b0;
        mode         = RX_ALWAYS;
        mode_left    = 0;
        hold_left    = 0;
        holds_taken  = 0;
        stall_mask   = 8'b1011_0010;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_taken) begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                stall_mask = {stall_mask[6:0], stall_mask[7]};
                case (mode)
                    RX_ALWAYS: res_if.ready <= 1'b1;
                    RX_HALF:   res_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_if.ready <= stall_mask[0];
                endcase
            end
        end
    end

    // Ends the run if no transfer happens for too long; the store clear after reset is the
    // longest legitimate quiet stretch.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && ((pix_if.valid && pix_if.ready) ||
                                     (res_if.valid && res_if.ready)))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned           k, f, r, roll, frame_len, frame_count;
        bit                    pressure_done;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] value;

        board             = new();
        pix_if.valid      = 1'b0;
        pix_if.pixel_gray = '0;
        pix_if.frame_end  = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_LEFT_A;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;
        pressure_done     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b0 | 1'b1;

        // With the reset geometry no zone reaches row 0, so positions stay at their origin.
        send_pixel(8'd255, 1'b1);
        quiesce();

        // Small zones on the top row; the third starts on the last column, partly off frame.
        write_reg(CFG_LEFT_A, 16'd0);
        write_reg(CFG_LEFT_B, 16'd2);
        write_reg(CFG_LEFT_C, 16'd639);
        write_reg(CFG_TOP, 16'd0);
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_GOAL, 16'd479);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        quiesce();

        // Zero width gives a zero area and hence a zero mean.
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd480);
        write_reg(CFG_THRESHOLD, 16'd65535);
        write_reg(CFG_GOAL, 16'd0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd17, 1'b0);
        send_pixel(8'd0, 1'b1);
        quiesce();

        // A register change part-way through a frame applies from the next pixel on.
        write_reg(CFG_WIDTH, 16'd2);
        write_reg(CFG_HEIGHT, 16'd511);
        write_reg(CFG_THRESHOLD, 16'd100);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        quiesce();
        write_reg(CFG_LEFT_A, 16'd1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);

        // Random phases: fresh register values, then a few short frames.
        while (pixels_sent < ITEM_TARGET || board.reports_checked < REPORT_TARGET) begin
            quiesce();
            for (r = 0; r < 8; r++) begin
                if ($urandom_range(0, 1) == 1) begin
                    idx  = t_cfg_idx'(r);
                    roll = $urandom_range(0, 7);
                    case (idx)
                        CFG_LEFT_A, CFG_LEFT_B, CFG_LEFT_C:
                            value = (roll == 1) ? 16'd0 : (roll == 2) ? 16'd639 :
                                    (roll == 3) ? 16'd1023 : 16'($urandom_range(0, 40));
                        CFG_TOP:
                            value = (roll == 1) ? 16'd479 : (roll == 2) ? 16'd511 :
                                    (roll == 3) ? 16'd1 : 16'd0;
                        CFG_WIDTH:
                            value = (roll == 1) ? 16'd0 : (roll == 2) ? 16'd640 :
                                    (roll == 3) ? 16'd1023 : 16'($urandom_range(1, 12));
                        CFG_HEIGHT:
                            value = (roll == 1) ? 16'd0 : (roll == 2) ? 16'd480 :
                                    (roll == 3) ? 16'd511 : 16'($urandom_range(1, 4));
                        CFG_THRESHOLD:
                            value = (roll == 1) ? 16'd0 : (roll == 2) ? 16'd65535 :
                                    (roll == 3) ? 16'($urandom) :
                                    16'($urandom_range(0, 3000));
                        default:
                            value = (roll == 1) ? 16'd0 : (roll == 2) ? 16'd479 :
                                    (roll == 3) ? 16'd511 : 16'($urandom_range(0, 511));
                    endcase
                    // Now and then stray bits above the register width as well.
                    if (roll == 0)
                        value = 16'($urandom);
                    write_reg(idx, value);
                end
            end

            if (!pressure_done && pixels_sent >= ITEM_TARGET / 2) begin
                // The receiver holds off while back-to-back short frames fill the block.
                pressure_done = 1'b1;
                hold_requests <= hold_requests + 1;
                gaps_on = 1'b0;
                for (k = 0; k < 30; k++)
                    send_pixel(random_gray(), (k % 3) == 2);
                gaps_on = 1'b1;
            end else begin
                frame_count = $urandom_range(1, 4);
                for (f = 0; f < frame_count; f++) begin
                    frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(1, 12);
                    for (k = 0; k < frame_len; k++)
                        send_pixel(random_gray(), k == frame_len - 1);
                end
                // Sometimes leave a frame open across the next register change.
                if ($urandom_range(0, 4) == 0) begin
                    frame_len = $urandom_range(1, 6);
                    for (k = 0; k < frame_len; k++)
                        send_pixel(random_gray(), 1'b0);
                end
            end
        end

        quiesce();
        repeat (END_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
